>>> rtl/bhs_pkg.sv
// ----------------------------------------------------------------------------
// bhs_pkg
// Shared constants, types and address helpers of the bilinear height sampler.
// ----------------------------------------------------------------------------
package bhs_pkg;

	// Texture edge length; must be a power of two.
	localparam int TEX_SIZE   = 256;
	localparam int TEX_LOG2   = $clog2(TEX_SIZE);

	localparam int STORE_AW   = 16;
	localparam int NUM_BANKS  = 4;
	localparam int BANK_AW    = STORE_AW - 2;
	localparam int BANK_DEPTH = 1 << BANK_AW;

	localparam int DATA_W     = 32;
	localparam int FRAC_W     = 48;
	localparam int WGT_W      = 16;
	localparam int BW_W       = 2 * WGT_W + 1;
	localparam int ACC_W      = 66;
	localparam int CFG_IDX_W  = 2;

	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_A = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_INV_SCALE_B = CFG_IDX_W'(1);

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;
	localparam logic LAYER_A     = 1'b0;
	localparam logic LAYER_B     = 1'b1;

	localparam logic [DATA_W-1:0] INV_A_RESET = 32'd16777216;
	localparam logic [DATA_W-1:0] INV_B_RESET = 32'd134217728;

	localparam logic [WGT_W:0] WGT_ONE = {1'b1, {WGT_W{1'b0}}};
	localparam logic signed [ACC_W-1:0] ROUND_HALF =
		{{(ACC_W - 2 * WGT_W){1'b0}}, 1'b1, {(2 * WGT_W - 1){1'b0}}};

	typedef logic [TEX_LOG2-1:0]       tex_idx_t;
	typedef logic [STORE_AW-1:0]       store_addr_t;
	typedef logic [BANK_AW-1:0]        bank_addr_t;
	typedef logic [1:0]                bank_sel_t;
	typedef logic signed [DATA_W-1:0]  texel_t;
	typedef logic [DATA_W-1:0]         scale_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic [FRAC_W-1:0]         frac_t;
	typedef logic [WGT_W-1:0]          weight_t;
	typedef logic [BW_W-1:0]           bweight_t;
	typedef logic signed [ACC_W-1:0]   acc_t;

	typedef struct packed {
		logic        en;
		store_addr_t addr;
		texel_t      data;
	} texel_wr_t;

	typedef struct packed {
		texel_t height;
		logic   was_sample;
	} out_word_t;

	// Store address of a texel, wrapped to the store size.
	function automatic store_addr_t texel_addr(tex_idx_t row, tex_idx_t col);
		logic [2*TEX_LOG2+STORE_AW-1:0] ext;
		ext = {{STORE_AW{1'b0}}, row, col};
		return ext[STORE_AW-1:0];
	endfunction

	// The bank is picked by row parity and column parity.
	function automatic bank_sel_t bank_of(store_addr_t a);
		return {a[TEX_LOG2], a[0]};
	endfunction

	function automatic bank_addr_t word_of(store_addr_t a);
		return {a[STORE_AW-1:TEX_LOG2+1], a[TEX_LOG2-1:1]};
	endfunction

endpackage

>>> rtl/bhs_in_if.sv
// ----------------------------------------------------------------------------
// bhs_in_if
// Command channel: texel loads and sample requests.
// ----------------------------------------------------------------------------
interface bhs_in_if;
	import bhs_pkg::*;

	logic        valid;
	logic        ready;
	logic        func;
	logic        layer_sel;
	store_addr_t texel_addr;
	texel_t      texel_value;
	texel_t      pos_x;
	texel_t      pos_y;

	modport source (
		output valid, func, layer_sel, texel_addr, texel_value, pos_x, pos_y,
		input  ready
	);

	modport sink (
		input  valid, func, layer_sel, texel_addr, texel_value, pos_x, pos_y,
		output ready
	);

endinterface

>>> rtl/bhs_out_if.sv
// ----------------------------------------------------------------------------
// bhs_out_if
// Result channel: sampled height or load acknowledge.
// ----------------------------------------------------------------------------
interface bhs_out_if;
	import bhs_pkg::*;

	logic   valid;
	logic   ready;
	texel_t height;
	logic   was_sample;

	modport source (
		output valid, height, was_sample,
		input  ready
	);

	modport sink (
		input  valid, height, was_sample,
		output ready
	);

endinterface

>>> rtl/bhs_cfg_if.sv
// ----------------------------------------------------------------------------
// bhs_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface bhs_cfg_if;
	import bhs_pkg::*;

	logic     valid;
	logic     ready;
	cfg_idx_t index;
	scale_t   data;

	modport source (
		output valid, index, data,
		input  ready
	);

	modport sink (
		input  valid, index, data,
		output ready
	);

endinterface

>>> rtl/bhs_ram.sv
// ----------------------------------------------------------------------------
// bhs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bhs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/bhs_layer.sv
// ----------------------------------------------------------------------------
// bhs_layer
// One height layer: four parity banks, wrapped coordinate decode and the
// bilinear blend, pipelined from the registered command to a Q16.16 value.
// ----------------------------------------------------------------------------
module bhs_layer (
	input  logic               clk,
	input  bhs_pkg::scale_t    inv_scale,
	input  bhs_pkg::texel_t    pos_x_s1,
	input  bhs_pkg::texel_t    pos_y_s1,
	input  bhs_pkg::texel_wr_t wr_s2,
	output bhs_pkg::texel_t    value_s6
);
	import bhs_pkg::*;

	// Integer part of the shifted coordinate.
	function automatic tex_idx_t axis_idx(frac_t f);
		logic [TEX_LOG2:0] d;
		d = f[FRAC_W-1 -: TEX_LOG2+1] - (TEX_LOG2+1)'(1);
		return d[TEX_LOG2:1];
	endfunction

	// Fraction of the shifted coordinate, truncated to Q0.16.
	function automatic weight_t axis_wgt(frac_t f);
		logic [TEX_LOG2:0] d;
		d = f[FRAC_W-1 -: TEX_LOG2+1] - (TEX_LOG2+1)'(1);
		return {d[0], f[FRAC_W-2-TEX_LOG2 -: WGT_W-1]};
	endfunction

	logic signed [2*DATA_W:0] px;
	logic signed [2*DATA_W:0] py;
	frac_t                    fx_s2;
	frac_t                    fy_s2;

	tex_idx_t                 ix0, ix1, iy0, iy1;
	weight_t                  wa, wb;
	logic [WGT_W:0]           oma, omb;
	logic [2*WGT_W+1:0]       w_c [NUM_BANKS];

	bweight_t                 bw_s3 [NUM_BANKS];
	bank_sel_t                par_s3;
	logic [DATA_W-1:0]        rdata_s3 [NUM_BANKS];

	acc_t                     prod_c [NUM_BANKS];
	acc_t                     prod_s4 [NUM_BANKS];
	acc_t                     sum_a_s5;
	acc_t                     sum_b_s5;
	acc_t                     total;

	assign px = $signed(pos_x_s1) * $signed({1'b0, inv_scale});
	assign py = $signed(pos_y_s1) * $signed({1'b0, inv_scale});

	always_ff @(posedge clk) begin
		fx_s2 <= px[FRAC_W-1:0];
		fy_s2 <= py[FRAC_W-1:0];
	end

	always_comb begin
		ix0 = axis_idx(fx_s2);
		iy0 = axis_idx(fy_s2);
		ix1 = ix0 + tex_idx_t'(1);
		iy1 = iy0 + tex_idx_t'(1);
		wa  = axis_wgt(fx_s2);
		wb  = axis_wgt(fy_s2);
		oma = WGT_ONE - {1'b0, wa};
		omb = WGT_ONE - {1'b0, wb};
		w_c[0] = oma * omb;
		w_c[1] = {1'b0, wa} * omb;
		w_c[2] = oma * {1'b0, wb};
		w_c[3] = {1'b0, wa} * {1'b0, wb};
	end

	// The four neighbours always differ in row or column parity, so each
	// bank serves exactly one of them.
	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		localparam logic ROW_PAR = 1'((b / 2) % 2);
		localparam logic COL_PAR = 1'(b % 2);

		tex_idx_t    row;
		tex_idx_t    col;
		store_addr_t rd_addr;

		assign row     = (iy0[0] == ROW_PAR) ? iy0 : iy1;
		assign col     = (ix0[0] == COL_PAR) ? ix0 : ix1;
		assign rd_addr = texel_addr(row, col);

		bhs_ram #(
			.WIDTH (DATA_W),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (wr_s2.en && (bank_of(wr_s2.addr) == bank_sel_t'(b))),
			.waddr (word_of(wr_s2.addr)),
			.wdata (wr_s2.data),
			.raddr (word_of(rd_addr)),
			.rdata (rdata_s3[b])
		);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_BANKS; k++) begin
			bw_s3[k] <= w_c[k][BW_W-1:0];
		end
		par_s3 <= {iy0[0], ix0[0]};
	end

	always_comb begin
		for (int k = 0; k < NUM_BANKS; k++) begin
			prod_c[k] = $signed(rdata_s3[par_s3 ^ bank_sel_t'(k)])
				* $signed({1'b0, bw_s3[k]});
		end
	end

	always_ff @(posedge clk) begin
		prod_s4  <= prod_c;
		sum_a_s5 <= prod_s4[0] + prod_s4[1];
		sum_b_s5 <= prod_s4[2] + prod_s4[3];
	end

	assign total = sum_a_s5 + sum_b_s5 + ROUND_HALF;

	always_ff @(posedge clk) begin
		value_s6 <= total[2*WGT_W+DATA_W-1:2*WGT_W];
	end

endmodule

>>> rtl/wrapped_bilinear_height_sampler.sv
// ----------------------------------------------------------------------------
// wrapped_bilinear_height_sampler
// Two wrapped height layers with texel load and bilinear sampling.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word
//  cmd      in   func, layer_sel, texel_addr, texel_value, pos_x, pos_y
//  res      out  height, was_sample
//  cfg      in   index, data (inverse scale of layer A or B)
//
//  One command word is taken per cycle while cmd.ready is high.
//  Each layer keeps four banks split by row and column parity, so the four
//  neighbours of a sample are read in the same cycle from separate banks.
//  Reset clears the pipeline and the result queue and loads the scale
//  registers; texel memories keep their contents.
//  A 16-word result queue absorbs stalls; cmd.ready falls only when 16 words
//  are in flight.
// ----------------------------------------------------------------------------
module wrapped_bilinear_height_sampler (
	input logic      clk,
	input logic      arst_n,
	bhs_in_if.sink   cmd,
	bhs_out_if.source res,
	bhs_cfg_if.sink  cfg
);
	import bhs_pkg::*;

	scale_t              inv_a_q;
	scale_t              inv_b_q;

	logic                cmd_acc;
	logic                res_pop;
	logic [FIFO_AW:0]    used_q;

	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic                func_s1, func_s2, func_s3, func_s4, func_s5, func_s6;
	logic                layer_s1, layer_s2;
	store_addr_t         addr_s1, addr_s2;
	texel_t              tdata_s1, tdata_s2;
	texel_t              pos_x_s1, pos_y_s1;

	texel_wr_t           wr_a_s2;
	texel_wr_t           wr_b_s2;
	texel_t              value_a_s6;
	texel_t              value_b_s6;

	logic signed [DATA_W:0]   pair_sum;
	logic signed [DATA_W+1:0] neg_sum;
	texel_t                   sat;
	out_word_t                push_word;

	out_word_t           fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_AW:0]    fill_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_a_q <= INV_A_RESET;
			inv_b_q <= INV_B_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_INV_SCALE_A: inv_a_q <= cfg.data;
				CFG_INV_SCALE_B: inv_b_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cmd.ready = (used_q != (FIFO_AW+1)'(FIFO_DEPTH));
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign res_pop   = res.valid && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			used_q <= used_q + (FIFO_AW+1)'(cmd_acc) - (FIFO_AW+1)'(res_pop);
			vld_s1 <= cmd_acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		func_s1  <= cmd.func;
		layer_s1 <= cmd.layer_sel;
		addr_s1  <= cmd.texel_addr;
		tdata_s1 <= cmd.texel_value;
		pos_x_s1 <= cmd.pos_x;
		pos_y_s1 <= cmd.pos_y;
		func_s2  <= func_s1;
		layer_s2 <= layer_s1;
		addr_s2  <= addr_s1;
		tdata_s2 <= tdata_s1;
		func_s3  <= func_s2;
		func_s4  <= func_s3;
		func_s5  <= func_s4;
		func_s6  <= func_s5;
	end

	// Loads write in the same stage in which samples read, so program order
	// is kept between them.
	always_comb begin
		wr_a_s2.en   = vld_s2 && (func_s2 == FUNC_LOAD) && (layer_s2 == LAYER_A);
		wr_a_s2.addr = addr_s2;
		wr_a_s2.data = tdata_s2;
		wr_b_s2.en   = vld_s2 && (func_s2 == FUNC_LOAD) && (layer_s2 == LAYER_B);
		wr_b_s2.addr = addr_s2;
		wr_b_s2.data = tdata_s2;
	end

	bhs_layer u_layer_a (
		.clk       (clk),
		.inv_scale (inv_a_q),
		.pos_x_s1  (pos_x_s1),
		.pos_y_s1  (pos_y_s1),
		.wr_s2     (wr_a_s2),
		.value_s6  (value_a_s6)
	);

	bhs_layer u_layer_b (
		.clk       (clk),
		.inv_scale (inv_b_q),
		.pos_x_s1  (pos_x_s1),
		.pos_y_s1  (pos_y_s1),
		.wr_s2     (wr_b_s2),
		.value_s6  (value_b_s6)
	);

	always_comb begin
		pair_sum = {value_a_s6[DATA_W-1], value_a_s6}
			+ {value_b_s6[DATA_W-1], value_b_s6};
		neg_sum  = (DATA_W+2)'(0) - {pair_sum[DATA_W], pair_sum};
		if ((neg_sum[DATA_W+1:DATA_W-1] == 3'b000)
			|| (neg_sum[DATA_W+1:DATA_W-1] == 3'b111)) begin
			sat = neg_sum[DATA_W-1:0];
		end else if (neg_sum[DATA_W+1]) begin
			sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
		push_word.height     = (func_s6 == FUNC_SAMPLE) ? sat : '0;
		push_word.was_sample = func_s6;
	end

	always_ff @(posedge clk) begin
		if (vld_s6) begin
			fifo_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (vld_s6) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (res_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			fill_q <= fill_q + (FIFO_AW+1)'(vld_s6) - (FIFO_AW+1)'(res_pop);
		end
	end

	assign res.valid      = (fill_q != '0);
	assign res.height     = fifo_q[rd_ptr_q].height;
	assign res.was_sample = fifo_q[rd_ptr_q].was_sample;

endmodule

>>> verif/tb_wrapped_bilinear_height_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wrapped_bilinear_height_sampler
// Self-checking bench for the two-layer wrapped bilinear height sampler.
// Before each sample word, every texel that it reads and that has not been
// loaded yet is loaded first, so no sample can touch an unwritten texel. A
// short directed part drives saturation in both directions, extreme positions
// and edge addresses. Random loads and samples follow under several scale
// settings, including zero and all-ones scales. Every accepted command word
// is fed into a bit-exact software predictor, and each result word is checked
// against the oldest pending prediction. Random gaps on the command side and
// random stalls on the result side are applied, and two long result stalls
// fill the block until it backs up its command input.
// ----------------------------------------------------------------------------
module tb_wrapped_bilinear_height_sampler;
	import bhs_pkg::*;

	localparam int  CLK_HALF      = 6;
	localparam int  RESET_CYCLES  = 9;
	localparam int  SETTLE_CYCLES = 12;
	localparam int  CYCLE_LIMIT   = 1_500_000;
	localparam int  LONG_HOLD     = 250;
	localparam int  MAX_REPORTS   = 50;
	localparam int  STORE_WORDS   = 1 << STORE_AW;
	localparam longint HEIGHT_MAX = 64'sd2147483647;
	localparam longint HEIGHT_MIN = -64'sd2147483648;
	localparam cfg_idx_t CFG_SPARE = cfg_idx_t'(3);
	// 10.5 m in Q16.16; lands on texel 10 of layer A and between 83 and 84 of
	// layer B with the reset scales.
	localparam texel_t PROBE_POS  = 32'sd688128;
	localparam texel_t TEXEL_MAX  = 32'sh7FFF_FFFF;
	localparam texel_t TEXEL_MIN  = 32'sh8000_0000;

	typedef struct {
		logic        func;
		logic        layer_sel;
		store_addr_t addr;
		texel_t      value;
		texel_t      pos_x;
		texel_t      pos_y;
	} cmd_word_t;

	logic clk;
	logic arst_n;

	bhs_in_if  cmd_bus ();
	bhs_out_if res_bus ();
	bhs_cfg_if cfg_bus ();

	wrapped_bilinear_height_sampler DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus),
		.res    (res_bus),
		.cfg    (cfg_bus)
	);

	cmd_word_t pending_words[$];
	out_word_t awaited_heights[$];
	texel_t    texel_mem [2][STORE_WORDS];
	bit        texel_loaded [2][STORE_WORDS];
	scale_t    scale_a;
	scale_t    scale_b;
	cmd_word_t on_bus;
	bit        pace_on;
	int        queued_count = 0;
	int        error_count  = 0;
	int        results_seen = 0;
	int        cycle_count  = 0;
	int        gap_left     = 0;
	int        stall_left   = 0;
	int        holds_taken  = 0;
	int        hold_marks[2] = '{150, 1000};

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic texel_t odd_value();
		case ($urandom_range(0, 4))
			0: return TEXEL_MIN;
			1: return TEXEL_MAX;
			2: return '0;
			3: return '1;
			default: return texel_t'(1);
		endcase
	endfunction

	function automatic texel_t random_pos();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return $signed($urandom);
		if (r < 80)
			return $signed($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
		return odd_value();
	endfunction

	function automatic texel_t fill_value();
		return $signed($urandom) >>> $urandom_range(0, 16);
	endfunction

	function automatic cmd_word_t make_load(logic lay, store_addr_t a, texel_t v);
		cmd_word_t w;
		w.func      = FUNC_LOAD;
		w.layer_sel = lay;
		w.addr      = a;
		w.value     = v;
		w.pos_x     = $signed($urandom);
		w.pos_y     = $signed($urandom);
		return w;
	endfunction

	function automatic cmd_word_t make_sample(texel_t x, texel_t y);
		cmd_word_t w;
		w.func      = FUNC_SAMPLE;
		w.layer_sel = $urandom_range(0, 1);
		w.addr      = $urandom;
		w.value     = $signed($urandom);
		w.pos_x     = x;
		w.pos_y     = y;
		return w;
	endfunction

	function automatic cmd_word_t random_load();
		texel_t v;
		v = ($urandom_range(0, 9) < 3) ? odd_value() : $signed($urandom);
		return make_load($urandom_range(0, 1), $urandom, v);
	endfunction

	// Wrapped texel coordinate along one axis: both neighbours and the weight.
	function automatic void wrap_axis(input texel_t pos, input scale_t inv,
			output int unsigned lo, output int unsigned hi, output int unsigned wgt);
		longint      prod;
		logic [63:0] shifted;
		prod    = longint'(pos) * longint'({32'b0, inv});
		shifted = {16'b0, prod[FRAC_W-1:0]} * 64'(TEX_SIZE) + (64'(TEX_SIZE) << FRAC_W)
			- (64'd1 << (FRAC_W - 1));
		lo  = int'((shifted >> FRAC_W) % 64'(TEX_SIZE));
		hi  = (lo + 1) % TEX_SIZE;
		wgt = shifted[FRAC_W-1 -: WGT_W];
	endfunction

	function automatic texel_t texel_at(logic lay, int unsigned row, int unsigned col);
		return texel_mem[lay][store_addr_t'(row * TEX_SIZE + col)];
	endfunction

	function automatic longint layer_height(logic lay, scale_t inv, texel_t x, texel_t y);
		int unsigned c0, c1, r0, r1, wa, wb;
		longint      ua, ub;
		acc_t        acc;
		wrap_axis(x, inv, c0, c1, wa);
		wrap_axis(y, inv, r0, r1, wb);
		ua  = longint'(1 << WGT_W) - longint'(wa);
		ub  = longint'(1 << WGT_W) - longint'(wb);
		acc = acc_t'(texel_at(lay, r0, c0)) * acc_t'(ua * ub)
			+ acc_t'(texel_at(lay, r0, c1)) * acc_t'(longint'(wa) * ub)
			+ acc_t'(texel_at(lay, r1, c0)) * acc_t'(ua * longint'(wb))
			+ acc_t'(texel_at(lay, r1, c1)) * acc_t'(longint'(wa) * longint'(wb));
		acc = acc + ROUND_HALF;
		return longint'(acc >>> 32);
	endfunction

	// Applies one accepted word to the texel copy and returns its result word.
	function automatic out_word_t absorb_word(cmd_word_t w);
		out_word_t r;
		longint    z;
		if (w.func == FUNC_LOAD) begin
			texel_mem[w.layer_sel][w.addr] = w.value;
			r.height     = '0;
			r.was_sample = 1'b0;
		end else begin
			z = -(layer_height(LAYER_A, scale_a, w.pos_x, w.pos_y)
				+ layer_height(LAYER_B, scale_b, w.pos_x, w.pos_y));
			if (z > HEIGHT_MAX)
				z = HEIGHT_MAX;
			if (z < HEIGHT_MIN)
				z = HEIGHT_MIN;
			r.height     = texel_t'(z);
			r.was_sample = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic signed [63:0] got,
			logic signed [63:0] want);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_words.size() != 0 || cmd_bus.valid || awaited_heights.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, scale_t val);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		if (idx == CFG_INV_SCALE_A)
			scale_a = val;
		else if (idx == CFG_INV_SCALE_B)
			scale_b = val;
	endtask

	task automatic enqueue_word(cmd_word_t w);
		if (w.func == FUNC_LOAD)
			texel_loaded[w.layer_sel][w.addr] = 1'b1;
		pending_words.insert(pending_words.size(), w);
		queued_count++;
	endtask

	// Loads every texel that the sample reads and that is not loaded yet, then
	// queues the sample itself with the scales that will be in force.
	task automatic queue_sample(texel_t x, texel_t y);
		int unsigned c0, c1, r0, r1, wa, wb;
		scale_t      inv;
		store_addr_t a;
		for (int lay = 0; lay < 2; lay++) begin
			inv = (lay == 0) ? scale_a : scale_b;
			wrap_axis(x, inv, c0, c1, wa);
			wrap_axis(y, inv, r0, r1, wb);
			for (int k = 0; k < 4; k++) begin
				a = store_addr_t'(((k < 2) ? r0 : r1) * TEX_SIZE
					+ ((k % 2 == 0) ? c0 : c1));
				if (!texel_loaded[lay][a])
					enqueue_word(make_load(lay[0], a, fill_value()));
			end
		end
		enqueue_word(make_sample(x, y));
	endtask

	task automatic queue_random(int n);
		int start;
		start = queued_count;
		while (queued_count - start < n) begin
			if ($urandom_range(0, 99) < 35)
				enqueue_word(random_load());
			else
				queue_sample(random_pos(), random_pos());
		end
		wait_idle();
	endtask

	// Covers the probe texels of both layers with one value and samples there.
	task automatic queue_probe(texel_t v);
		enqueue_word(make_load(LAYER_A, store_addr_t'(10 * TEX_SIZE + 10), v));
		for (int r = 83; r <= 84; r++)
			for (int c = 83; c <= 84; c++)
				enqueue_word(make_load(LAYER_B, store_addr_t'(r * TEX_SIZE + c), v));
		queue_sample(PROBE_POS, PROBE_POS);
	endtask

	always @(posedge clk) begin : driver
		cmd_word_t nxt;
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			gap_left      <= 0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready)
				awaited_heights.insert(awaited_heights.size(), absorb_word(on_bus));
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (gap_left > 0) begin
					gap_left      <= gap_left - 1;
					cmd_bus.valid <= 1'b0;
				end else if (pending_words.size() != 0) begin
					nxt = pending_words.pop_front();
					on_bus                <= nxt;
					cmd_bus.func          <= nxt.func;
					cmd_bus.layer_sel     <= nxt.layer_sel;
					cmd_bus.texel_addr    <= nxt.addr;
					cmd_bus.texel_value   <= nxt.value;
					cmd_bus.pos_x         <= nxt.pos_x;
					cmd_bus.pos_y         <= nxt.pos_y;
					cmd_bus.valid         <= 1'b1;
					gap_left              <= pace_on ? pick_pause() : 0;
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_pacer
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			stall_left    <= 0;
		end else if (holds_taken < 2 && results_seen >= hold_marks[holds_taken]) begin
			holds_taken   <= holds_taken + 1;
			stall_left    <= LONG_HOLD - 1;
			res_bus.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left    <= stall_left - 1;
			res_bus.ready <= 1'b0;
		end else if (pace_on && $urandom_range(0, 3) == 0) begin
			stall_left    <= pick_pause();
			res_bus.ready <= 1'b0;
		end else begin
			res_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : monitor
		out_word_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			results_seen <= results_seen + 1;
			if (awaited_heights.size() == 0) begin
				report_mismatch("unawaited word, height", res_bus.height, 0);
			end else begin
				want = awaited_heights.pop_front();
				if (res_bus.height !== want.height)
					report_mismatch("height", res_bus.height, want.height);
				if (res_bus.was_sample !== want.was_sample)
					report_mismatch("was_sample", res_bus.was_sample, want.was_sample);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n              = 1'b0;
		pace_on             = 1'b0;
		cmd_bus.valid       = 1'b0;
		cmd_bus.func        = FUNC_LOAD;
		cmd_bus.layer_sel   = LAYER_A;
		cmd_bus.texel_addr  = '0;
		cmd_bus.texel_value = '0;
		cmd_bus.pos_x       = '0;
		cmd_bus.pos_y       = '0;
		res_bus.ready       = 1'b0;
		cfg_bus.valid       = 1'b0;
		cfg_bus.index       = CFG_INV_SCALE_A;
		cfg_bus.data        = '0;
		scale_a             = INV_A_RESET;
		scale_b             = INV_B_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		queue_probe(TEXEL_MAX);
		queue_probe(TEXEL_MIN);
		queue_sample(TEXEL_MIN, TEXEL_MAX);
		queue_sample(TEXEL_MAX, TEXEL_MIN);
		queue_sample('0, '0);
		queue_sample('1, '1);
		enqueue_word(make_load(LAYER_A, '0, '0));
		enqueue_word(make_load(LAYER_B, '1, '1));
		queue_sample(32'sd32768, 32'sd32768);
		wait_idle();

		pace_on = 1'b1;
		queue_random(450);

		write_reg(CFG_INV_SCALE_A, '0);
		write_reg(CFG_INV_SCALE_B, '1);
		pace_on = 1'b0;
		queue_random(300);

		write_reg(CFG_INV_SCALE_A, '1);
		write_reg(CFG_INV_SCALE_B, '0);
		write_reg(CFG_SPARE, $urandom);
		pace_on = 1'b1;
		queue_random(300);

		write_reg(CFG_INV_SCALE_A, $urandom);
		write_reg(CFG_INV_SCALE_B, $urandom);
		queue_random(300);

		write_reg(CFG_INV_SCALE_A, $urandom);
		write_reg(CFG_INV_SCALE_B, $urandom);
		queue_random(250);

		write_reg(CFG_INV_SCALE_A, scale_t'(1));
		write_reg(CFG_INV_SCALE_B, 32'h8000_0000);
		queue_random(200);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> files.f
rtl/bhs_pkg.sv
rtl/bhs_in_if.sv
rtl/bhs_out_if.sv
rtl/bhs_cfg_if.sv
rtl/bhs_ram.sv
rtl/bhs_layer.sv
rtl/wrapped_bilinear_height_sampler.sv
verif/tb_wrapped_bilinear_height_sampler.sv
